// ----- sv/ols_pkg.sv -----
// Shared types and constants for the ordered list store.
// Holds the request and response word types, the request kinds and the status codes.
// No dependencies.
package ols_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   localparam logic [2:0] KIND_PUSH   = 3'd0;
   localparam logic [2:0] KIND_INSERT = 3'd1;
   localparam logic [2:0] KIND_DELETE = 3'd2;
   localparam logic [2:0] KIND_POP    = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;
   localparam logic [2:0] KIND_FIND   = 3'd5;
   localparam logic [2:0] KIND_REMOVE = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic [6:0]         position;
      logic signed [31:0] word;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_word;
      logic               found;
      logic [5:0]         found_position;
      logic [6:0]         count;
      logic [1:0]         status;
   } rsp_type;

endpackage

// ----- sv/ordered_list_store_core.sv -----
// Ordered list store: a list of signed 32-bit words kept in order in a 64-entry memory.
// Depends on ols_pkg for types and codes and on ols_ram for the entry store.
//
// A request word is taken on req_item at a clock edge where start is high and busy is low.
// Exactly one response word appears on rsp_item for one cycle, marked by rsp_strobe; the
// receiver cannot stall it, and it may be accepted while the next request is already taken.
// Push, every error, unused kinds, and find or remove on an empty list answer in the cycle
// after the request is taken, with busy never raised. Read and pop go through the read and
// process states and answer from the memory's registered output. The other kinds walk the
// memory under a small sequencer that alternates the read and process states, one entry per
// pass, reading through the single memory read port and writing through the write port:
//    insert  walks down from the count to the position,
//    delete  walks up from the position to the end of the list,
//    find    walks up from the first entry to the first match or the end of the list,
//    remove  walks the whole list.
// Reset clears the count and the sequencer; the entries need no clearing since only
// positions below the count are ever read.
module ordered_list_store_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ols_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ols_pkg::rsp_type rsp_item
);

   localparam int CW = ols_pkg::CNT_W;
   localparam int AW = ols_pkg::ADDR_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_PROC = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         kind_ff, kind_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [31:0]        word_ff, word_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      wp_ff, wp_in;
   logic [31:0]        res_ff, res_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   ols_pkg::rsp_type   rsp_ff, rsp_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_data;

   logic               accept;
   logic               full;
   logic [CW-1:0]      idx_inc;
   logic               last;
   logic               drop;

   ols_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == ols_pkg::DEPTH_CNT);
   assign idx_inc = idx_ff + CW'(1);
   assign last   = (idx_inc == count_ff);
   assign drop   = (kind_ff == ols_pkg::KIND_DELETE) ? (idx_ff == pos_ff)
                                                     : (rd_data == word_ff);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      res_in        = res_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rd_data;
      rd_addr       = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_item.kind;
               pos_in  = req_item.position;
               word_in = req_item.word;
               idx_in  = '0;
               wp_in   = '0;
               res_in  = '0;
               case (req_item.kind)
                  ols_pkg::KIND_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_in.status = ols_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_item.word;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ols_pkg::KIND_INSERT: begin
                     if (req_item.position > count_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ols_pkg::ST_RANGE;
                     end else if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ols_pkg::ST_FULL;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_RD;
                     end
                  end
                  ols_pkg::KIND_DELETE, ols_pkg::KIND_READ: begin
                     if (req_item.position >= count_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ols_pkg::ST_RANGE;
                     end else begin
                        idx_in   = req_item.position;
                        wp_in    = req_item.position;
                        state_in = S_RD;
                     end
                  end
                  ols_pkg::KIND_POP: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ols_pkg::ST_EMPTY;
                     end else begin
                        idx_in   = count_ff - CW'(1);
                        state_in = S_RD;
                     end
                  end
                  ols_pkg::KIND_FIND, ols_pkg::KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_RD: begin
            if (kind_ff == ols_pkg::KIND_INSERT) begin
               if (idx_ff == pos_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = pos_ff[AW-1:0];
                  wr_data       = word_ff;
                  count_in      = count_ff + CW'(1);
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  rd_addr  = idx_ff[AW-1:0] - AW'(1);
                  state_in = S_PROC;
               end
            end else begin
               state_in = S_PROC;
            end
         end
         S_PROC: begin
            case (kind_ff)
               ols_pkg::KIND_INSERT: begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[AW-1:0];
                  idx_in   = idx_ff - CW'(1);
                  state_in = S_RD;
               end
               ols_pkg::KIND_POP: begin
                  count_in           = count_ff - CW'(1);
                  rsp_in.result_word = rd_data;
                  rsp_strobe_in      = 1'b1;
                  state_in           = S_IDLE;
               end
               ols_pkg::KIND_READ: begin
                  rsp_in.result_word = rd_data;
                  rsp_strobe_in      = 1'b1;
                  state_in           = S_IDLE;
               end
               ols_pkg::KIND_FIND: begin
                  if (rd_data == word_ff) begin
                     rsp_in.found          = 1'b1;
                     rsp_in.found_position = idx_ff[5:0];
                     rsp_strobe_in         = 1'b1;
                     state_in              = S_IDLE;
                  end else if (last) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in   = idx_inc;
                     state_in = S_RD;
                  end
               end
               ols_pkg::KIND_DELETE, ols_pkg::KIND_REMOVE: begin
                  if (drop) begin
                     res_in = (kind_ff == ols_pkg::KIND_DELETE) ? rd_data
                                                               : res_ff + 32'd1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = wp_ff[AW-1:0];
                     wp_in   = wp_ff + CW'(1);
                  end
                  if (last) begin
                     count_in           = wp_in;
                     rsp_in.result_word = res_in;
                     rsp_strobe_in      = 1'b1;
                     state_in           = S_IDLE;
                  end else begin
                     idx_in   = idx_inc;
                     state_in = S_RD;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
      word_ff <= word_in;
      idx_ff  <= idx_in;
      wp_ff   <= wp_in;
      res_ff  <= res_in;
      if (rsp_strobe_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- sv/ols_ram.sv -----
// Entry store for the ordered list: one write port and one read port with registered data.
// Depends on ols_pkg for the depth and address width.
module ols_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ols_pkg::ADDR_W-1:0] wr_addr,
   input  logic [31:0]                wr_data,
   input  logic [ols_pkg::ADDR_W-1:0] rd_addr,
   output logic [31:0]                rd_data
);

   logic [31:0] mem [ols_pkg::DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/ordered_list_store_core_tb.sv -----
// Self-checking testbench for ordered_list_store_core: a directed opening, then random requests.
// Each accepted request word goes through an in-bench model of the list, and every response
// word is checked against it. Depends on ols_pkg and the core.
module ordered_list_store_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int RANDOM_WORDS = 1350;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 1000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ols_pkg::req_type req_item = '0;
   logic             rsp_strobe;
   ols_pkg::rsp_type rsp_item;

   ols_pkg::req_type pending_reqs [$];
   ols_pkg::rsp_type expected_rsps [$];
   logic [31:0]      list_words [ols_pkg::DEPTH];
   int               list_fill = 0;
   int               mismatch_count = 0;
   int unsigned      cycle_count = 0;
   bit               took_item = 1'b0;
   int               idle_left = 0;
   int               burst_left = 0;
   ols_pkg::req_type noise_item;

   ordered_list_store_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void list_clear();
      foreach (list_words[i]) list_words[i] = '0;
      list_fill = 0;
   endfunction

   function automatic ols_pkg::rsp_type apply_request(ols_pkg::req_type r);
      ols_pkg::rsp_type o;
      int               p;
      int               i;
      o = '0;
      p = int'(r.position);
      case (r.kind)
         ols_pkg::KIND_PUSH: begin
            if (list_fill >= ols_pkg::DEPTH) begin
               o.status = ols_pkg::ST_FULL;
            end else begin
               list_words[list_fill] = r.word;
               list_fill++;
            end
         end
         ols_pkg::KIND_INSERT: begin
            if (p > list_fill) begin
               o.status = ols_pkg::ST_RANGE;
            end else if (list_fill >= ols_pkg::DEPTH) begin
               o.status = ols_pkg::ST_FULL;
            end else begin
               for (i = list_fill; i > p; i--) list_words[i] = list_words[i - 1];
               list_words[p] = r.word;
               list_fill++;
            end
         end
         ols_pkg::KIND_DELETE: begin
            if (p >= list_fill) begin
               o.status = ols_pkg::ST_RANGE;
            end else begin
               o.result_word = list_words[p];
               for (i = p; i + 1 < list_fill; i++) list_words[i] = list_words[i + 1];
               list_fill--;
            end
         end
         ols_pkg::KIND_POP: begin
            if (list_fill == 0) begin
               o.status = ols_pkg::ST_EMPTY;
            end else begin
               list_fill--;
               o.result_word = list_words[list_fill];
            end
         end
         ols_pkg::KIND_READ: begin
            if (p >= list_fill) o.status = ols_pkg::ST_RANGE;
            else o.result_word = list_words[p];
         end
         ols_pkg::KIND_FIND: begin
            for (i = 0; i < list_fill; i++) begin
               if (!o.found && list_words[i] == r.word) begin
                  o.found = 1'b1;
                  o.found_position = 6'(i);
               end
            end
         end
         ols_pkg::KIND_REMOVE: begin
            i = 0;
            while (i < list_fill) begin
               if (list_words[i] == r.word) begin
                  for (p = i; p + 1 < list_fill; p++) list_words[p] = list_words[p + 1];
                  list_fill--;
                  o.result_word = o.result_word + 32'sd1;
               end else begin
                  i++;
               end
            end
         end
         default: begin
         end
      endcase
      o.count = 7'(list_fill);
      return o;
   endfunction

   function automatic void queue_request(logic [2:0] kind, int position, logic [31:0] value);
      ols_pkg::req_type r;
      r.kind = kind;
      r.position = 7'(position);
      r.word = value;
      pending_reqs.push_back(r);
      void'(apply_request(r));
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (start && took_item) begin
            if (burst_left > 0) begin
               burst_left--;
               idle_left = 0;
            end else if ($urandom_range(0, 15) == 0) begin
               burst_left = $urandom_range(5, 30);
               idle_left = 0;
            end else begin
               idle_left = $urandom_range(0, 10);
            end
         end
         if (!start || took_item) begin
            if (idle_left == 0 && pending_reqs.size() != 0) begin
               req_item <= pending_reqs.pop_front();
               start <= 1'b1;
            end else begin
               noise_item.kind = 3'($urandom);
               noise_item.position = 7'($urandom);
               noise_item.word = $urandom;
               req_item <= noise_item;
               start <= 1'b0;
               if (idle_left != 0) idle_left--;
            end
         end
      end
   end

   always @(posedge clock) begin
      ols_pkg::rsp_type want;
      took_item = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("response word with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("result_word", want.result_word, rsp_item.result_word);
               check_field("found", 32'(want.found), 32'(rsp_item.found));
               check_field("found_position", 32'(want.found_position),
                           32'(rsp_item.found_position));
               check_field("count", 32'(want.count), 32'(rsp_item.count));
               check_field("status", 32'(want.status), 32'(rsp_item.status));
            end
         end
         if (start && !busy) begin
            took_item = 1'b1;
            expected_rsps.push_back(apply_request(req_item));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [31:0] pool [8];
      logic [31:0] value;
      logic [2:0]  kind;
      int          counted;
      int          pick;
      int          pos;
      bit          growing;

      list_clear();
      queue_request(ols_pkg::KIND_POP, 0, 32'd0);
      queue_request(ols_pkg::KIND_READ, 0, 32'd0);
      queue_request(ols_pkg::KIND_DELETE, 0, 32'd0);
      queue_request(ols_pkg::KIND_FIND, 0, 32'hFFFF_FFFF);
      queue_request(ols_pkg::KIND_REMOVE, 0, 32'd0);
      queue_request(KIND_UNUSED, 127, 32'hFFFF_FFFF);
      queue_request(ols_pkg::KIND_INSERT, 1, 32'd5);
      queue_request(ols_pkg::KIND_INSERT, 0, 32'h8000_0000);
      queue_request(ols_pkg::KIND_PUSH, 0, 32'h7FFF_FFFF);
      queue_request(ols_pkg::KIND_PUSH, 0, 32'hFFFF_FFFF);
      queue_request(ols_pkg::KIND_PUSH, 0, 32'd0);
      queue_request(ols_pkg::KIND_FIND, 0, 32'hFFFF_FFFF);
      queue_request(ols_pkg::KIND_FIND, 0, 32'd5);
      queue_request(ols_pkg::KIND_READ, 127, 32'd0);
      queue_request(ols_pkg::KIND_INSERT, 4, 32'h5555_5555);
      queue_request(ols_pkg::KIND_DELETE, 1, 32'd0);
      queue_request(ols_pkg::KIND_REMOVE, 0, 32'd9);
      queue_request(ols_pkg::KIND_REMOVE, 0, 32'd0);
      while (list_fill < ols_pkg::DEPTH) begin
         queue_request(ols_pkg::KIND_PUSH, 0, (list_fill % 5 == 0) ? 32'hA5 : $urandom);
      end
      queue_request(ols_pkg::KIND_PUSH, 0, 32'd1);
      queue_request(ols_pkg::KIND_INSERT, 10, 32'd1);
      queue_request(ols_pkg::KIND_INSERT, 65, 32'd1);
      queue_request(ols_pkg::KIND_FIND, 0, list_words[ols_pkg::DEPTH - 1]);
      queue_request(ols_pkg::KIND_READ, ols_pkg::DEPTH - 1, 32'd0);
      queue_request(ols_pkg::KIND_DELETE, ols_pkg::DEPTH - 1, 32'd0);
      queue_request(ols_pkg::KIND_POP, 0, 32'd0);
      queue_request(ols_pkg::KIND_REMOVE, 0, 32'hA5);

      pool[0] = 32'd0;
      pool[1] = 32'd1;
      pool[2] = 32'hFFFF_FFFF;
      pool[3] = 32'h7FFF_FFFF;
      pool[4] = 32'h8000_0000;
      for (int i = 5; i < 8; i++) pool[i] = $urandom;
      counted = 0;
      growing = 1'b1;
      while (counted < RANDOM_WORDS) begin
         if (counted % 150 == 0) growing = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         value = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 7)];
         pos = 0;
         if (pick < 5) begin
            kind = 3'($urandom_range(0, 7));
            pos = $urandom_range(0, 127);
         end else if (pick < (growing ? 45 : 20)) begin
            kind = ols_pkg::KIND_PUSH;
         end else if (pick < (growing ? 60 : 35)) begin
            kind = ols_pkg::KIND_INSERT;
            pos = $urandom_range(0, list_fill);
         end else if (pick < (growing ? 68 : 55)) begin
            kind = ols_pkg::KIND_DELETE;
            pos = (list_fill > 0) ? $urandom_range(0, list_fill - 1) : 0;
         end else if (pick < (growing ? 74 : 70)) begin
            kind = ols_pkg::KIND_POP;
         end else if (pick < 84) begin
            kind = ols_pkg::KIND_READ;
            pos = (list_fill > 0) ? $urandom_range(0, list_fill - 1) : 0;
         end else if (pick < 94) begin
            kind = ols_pkg::KIND_FIND;
            if (list_fill > 0 && $urandom_range(0, 1) == 1)
               value = list_words[$urandom_range(0, list_fill - 1)];
         end else begin
            kind = ols_pkg::KIND_REMOVE;
         end
         queue_request(kind, pos, value);
         if (kind != KIND_UNUSED) counted++;
      end
      list_clear();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (pending_reqs.size() != 0 || start);
      do @(negedge clock); while (expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
